[rtl/vl2n_pkg.sv]
// Shared types and constants for the vector L2 normaliser.
// Used by the controller, the datapath and its arithmetic units.
`default_nettype none

package vl2n_pkg;

  localparam int unsigned SUM_W        = 40;            // running sum of squares
  localparam int unsigned NORM_W       = 20;            // integer square root of the sum
  localparam int unsigned OUT_W        = 16;            // Q1.15 result
  localparam int unsigned SQRT_STEPS   = SUM_W / 2;     // one root digit per step
  localparam int unsigned SQRT_CNT_W   = $clog2(SQRT_STEPS);
  localparam int unsigned SQRT_REM_W   = NORM_W + 2;
  localparam int unsigned DIV_STEPS    = OUT_W - 1;     // fraction bits of the quotient
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX   = '1;
  localparam logic [OUT_W-1:0] QUOT_SAT  = 16'h8000;
  localparam logic [OUT_W-1:0] POS_MAX   = 16'h7FFF;

  // stream kind codes
  localparam logic MODE_PUSH    = 1'b0;
  localparam logic MODE_POP     = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic push_load;   // take a pushed element, square it
    logic sum_add;     // add the registered square to the sum
    logic sqrt_start;  // start the root of the sum
    logic div_start;   // start dividing the read element by the norm
    logic out_load;    // load the output register
    logic out_empty;   // the loaded beat is an empty-status reply
  } vl2n_cmd_t;

  typedef struct packed {
    logic pop_ok;      // a finished vector has an unread element
    logic last_pend;   // the pushed element closed its vector
    logic sqrt_done;
    logic div_done;
    logic out_free;    // the output register can take a beat
  } vl2n_sts_t;

endpackage

`default_nettype wire

[rtl/vl2n_sqrt.sv]
// Bit-serial integer square root of the 40-bit sum, one root digit per cycle.
// Depends on vl2n_pkg for the sum and root widths.
`default_nettype none

module vl2n_sqrt import vl2n_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  radicand_i,
  output      logic              done_o,
  output      logic [NORM_W-1:0] root_o
);

  logic [SUM_W-1:0]      x_q;
  logic [SQRT_REM_W-1:0] rem_q;
  logic [NORM_W-1:0]     root_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic                  busy_q, done_q;

  logic [SQRT_REM_W+1:0] rem_ext, trial, diff;
  logic                  ge;

  // bring down the next two radicand bits and try root*4+1
  assign rem_ext = {rem_q, x_q[SUM_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_ext >= trial;
  assign diff    = rem_ext - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQRT_CNT_W'(SQRT_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - SQRT_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q <= {x_q[SUM_W-3:0], 2'b00};
      if (ge) begin
        rem_q  <= diff[SQRT_REM_W-1:0];
        root_q <= {root_q[NORM_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_ext[SQRT_REM_W-1:0];
        root_q <= {root_q[NORM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[rtl/vl2n_div.sv]
// Restoring divider: magnitude * 2^15 / norm, one quotient bit per cycle.
// Gives 0x8000 when the magnitude reaches the norm and 0 for a zero norm.
`default_nettype none

module vl2n_div import vl2n_pkg::*; #(
  parameter int unsigned MAG_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [MAG_W-1:0]  mag_i,
  input  wire logic [NORM_W-1:0] norm_i,
  output      logic              done_o,
  output      logic [OUT_W-1:0]  quot_o
);

  localparam int unsigned CMP_W = (MAG_W > NORM_W) ? MAG_W : NORM_W;

  logic [NORM_W-1:0]    rem_q, norm_q;
  logic [OUT_W-1:0]     quot_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  logic [CMP_W-1:0]  mag_ext, norm_ext;
  logic              early;
  logic [NORM_W:0]   rem2, sub;
  logic              ge;

  assign mag_ext  = CMP_W'(mag_i);
  assign norm_ext = CMP_W'(norm_i);
  // zero norm or a quotient of at least one settles at once
  assign early    = (norm_i == '0) || (mag_ext >= norm_ext);

  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, norm_q};
  assign sub  = rem2 - {1'b0, norm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !early;
        done_q <= early;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - DIV_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      norm_q <= norm_i;
      rem_q  <= mag_ext[NORM_W-1:0];
      if (norm_i == '0) begin
        quot_q <= '0;
      end else if (early) begin
        quot_q <= QUOT_SAT;
      end else begin
        quot_q <= '0;
      end
    end else if (busy_q) begin
      rem_q  <= ge ? sub[NORM_W-1:0] : rem2[NORM_W-1:0];
      quot_q <= {quot_q[OUT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[rtl/vl2n_dp.sv]
// Datapath: element memory, sum of squares, norm, read pointer and output register.
// Depends on vl2n_pkg, vl2n_sqrt and vl2n_div; driven by commands from vl2n_ctrl.
`default_nettype none

module vl2n_dp import vl2n_pkg::*; #(
  parameter int unsigned VECTOR_LENGTH = 512,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire vl2n_cmd_t                cmd_i,
  output      vl2n_sts_t                sts_o,
  input  wire logic [ELEMENT_WIDTH-1:0] elem_i,
  input  wire logic                     last_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic [OUT_W-1:0]         out_value_o,
  output      logic                     out_last_o,
  output      logic                     out_status_o
);

  localparam int unsigned EW    = ELEMENT_WIDTH;
  localparam int unsigned CNT_W = $clog2(VECTOR_LENGTH + 1);
  localparam int unsigned IDX_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int unsigned SQ_W  = 2 * EW;
  localparam int unsigned ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

  logic [EW-1:0]     mem_q [VECTOR_LENGTH];
  logic [EW-1:0]     rd_q;
  logic [SQ_W-1:0]   sq_q;
  logic [SUM_W-1:0]  sum_q;
  logic [NORM_W-1:0] norm_q;
  logic [CNT_W-1:0]  count_q, rp_q;
  logic              ready_q, store_q, last_q;
  logic              oval_q, olast_q, ostat_q;
  logic [OUT_W-1:0]  odata_q;

  logic [CNT_W-1:0]  count_eff;
  logic              store_ok;
  logic [EW-1:0]     mag_in, mag_rd;
  logic [SQ_W-1:0]   sq;
  logic [ACC_W-1:0]  acc;
  logic [SUM_W-1:0]  sum_sat;
  logic              final_one, out_free;
  logic              sqrt_done, div_done;
  logic [NORM_W-1:0] root;
  logic [OUT_W-1:0]  quot, res_neg, res;

  // a push onto a finished vector starts a fresh one
  assign count_eff = ready_q ? '0 : count_q;
  assign store_ok  = count_eff < CNT_W'(VECTOR_LENGTH);

  assign mag_in = elem_i[EW-1] ? (EW'(0) - elem_i) : elem_i;
  assign mag_rd = rd_q[EW-1] ? (EW'(0) - rd_q) : rd_q;
  assign sq     = SQ_W'(mag_in) * SQ_W'(mag_in);

  assign acc     = ACC_W'(sum_q) + ACC_W'(sq_q);
  assign sum_sat = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];

  assign final_one = (rp_q + CNT_W'(1)) == count_q;
  assign out_free  = !oval_q || out_ready_i;

  assign res_neg = OUT_W'(0) - quot;
  assign res     = rd_q[EW-1] ? res_neg : ((quot > POS_MAX) ? POS_MAX : quot);

  vl2n_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (sum_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  vl2n_div #(
    .MAG_W (EW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .mag_i   (mag_rd),
    .norm_i  (norm_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_load && store_ok) begin
      mem_q[count_eff[IDX_W-1:0]] <= elem_i;
    end
    rd_q <= mem_q[rp_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_load) begin
      sq_q <= sq;
    end
    if (cmd_i.out_load) begin
      odata_q <= cmd_i.out_empty ? '0 : res;
      olast_q <= cmd_i.out_empty ? 1'b0 : final_one;
      ostat_q <= cmd_i.out_empty ? STATUS_EMPTY : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      norm_q  <= '0;
      count_q <= '0;
      rp_q    <= '0;
      ready_q <= 1'b0;
      store_q <= 1'b0;
      last_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      if (cmd_i.push_load) begin
        if (ready_q) begin
          sum_q   <= '0;
          norm_q  <= '0;
          rp_q    <= '0;
          ready_q <= 1'b0;
        end
        count_q <= store_ok ? (count_eff + CNT_W'(1)) : count_eff;
        store_q <= store_ok;
        last_q  <= last_i;
      end
      if (cmd_i.sum_add && store_q) begin
        sum_q <= sum_sat;
      end
      if (sqrt_done) begin
        norm_q  <= root;
        rp_q    <= '0;
        ready_q <= 1'b1;
      end
      if (cmd_i.out_load && !cmd_i.out_empty) begin
        if (final_one) begin
          sum_q   <= '0;
          norm_q  <= '0;
          count_q <= '0;
          rp_q    <= '0;
          ready_q <= 1'b0;
        end else begin
          rp_q <= rp_q + CNT_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  assign sts_o.pop_ok    = ready_q && (rp_q < count_q);
  assign sts_o.last_pend = last_q;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = oval_q;
  assign out_value_o  = odata_q;
  assign out_last_o   = olast_q;
  assign out_status_o = ostat_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(VECTOR_LENGTH))
    else $error("element count beyond buffer depth");

  a_root_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |=> ready_q && rp_q == '0)
    else $error("finished root did not open the vector for reading");

  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && !cmd_i.out_empty && final_one |=> !ready_q && count_q == '0)
    else $error("final element did not free the vector");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output register loaded while a beat was still held");

endmodule

`default_nettype wire

[rtl/vl2n_ctrl.sv]
// Controller state machine: sequences push, root, read, divide and reply steps.
// Depends on vl2n_pkg for the command and status structs.
`default_nettype none

module vl2n_ctrl import vl2n_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_mode_i,
  output      logic      in_ready_o,
  input  wire vl2n_sts_t sts_i,
  output      vl2n_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_READ,
    S_DIV_WAIT,
    S_REPLY
  } state_e;

  state_e state_q;
  logic   empty_q;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.push_load  = accept && (in_mode_i == MODE_PUSH);
    cmd_o.sum_add    = (state_q == S_ADD);
    cmd_o.sqrt_start = (state_q == S_ROOT_GO);
    cmd_o.div_start  = (state_q == S_READ);
    cmd_o.out_load   = (state_q == S_REPLY) && sts_i.out_free;
    cmd_o.out_empty  = empty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      empty_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_mode_i == MODE_PUSH) begin
              state_q <= S_ADD;
            end else if (sts_i.pop_ok) begin
              empty_q <= 1'b0;
              state_q <= S_READ;
            end else begin
              empty_q <= 1'b1;
              state_q <= S_REPLY;
            end
          end
        end
        S_ADD: begin
          state_q <= sts_i.last_pend ? S_ROOT_GO : S_IDLE;
        end
        S_ROOT_GO: begin
          state_q <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (sts_i.sqrt_done) begin
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_div_only_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_root_only_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.sqrt_done |-> state_q == S_ROOT_WAIT)
    else $error("root finished outside its wait state");

  a_pop_reads_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_mode_i == MODE_POP && sts_i.pop_ok |=> state_q == S_READ)
    else $error("valid pop did not go to the memory read");

endmodule

`default_nettype wire

[rtl/vector_l2_normalizer.sv]
// Vector L2 normaliser. Push beats (tuser 0) store signed Q4.12 elements and add
// each square to a saturating 40-bit sum; the push with tlast set closes the vector
// and takes the integer square root of the sum (the norm). Pop beats (tuser 1) each
// give one reply beat: the next element divided by the norm as signed Q1.15,
// saturated at 32767 and -32768, tlast on the final element, tuser 1 when no finished
// vector is waiting. The closing push takes the root bit-serially, one digit per
// cycle. A pop reads the element and runs the restoring divider at one quotient
// bit per cycle, skipping the bit steps when the norm is zero or the quotient
// saturates; an empty pop goes straight to the reply. One beat is in work at a
// time, and a new one is taken while a reply waits in the output register.
// Pushes beyond VECTOR_LENGTH elements are dropped. No clearing pass after reset.
`default_nettype none

module vector_l2_normalizer import vl2n_pkg::*; #(
  parameter int unsigned VECTOR_LENGTH = 512,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  input  wire logic [((ELEMENT_WIDTH + 7) / 8) * 8 - 1:0]
                                      s_axis_tdata_i,   // element_value
  input  wire logic                   s_axis_tuser_i,   // mode
  input  wire logic                   s_axis_tlast_i,   // last
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output      logic [OUT_W-1:0]       m_axis_tdata_o,   // normalized_value
  output      logic                   m_axis_tuser_o,   // status
  output      logic                   m_axis_tlast_o    // last_element
);

  vl2n_cmd_t cmd;
  vl2n_sts_t sts;

  vl2n_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_mode_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vl2n_dp #(
    .VECTOR_LENGTH (VECTOR_LENGTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .elem_i       (s_axis_tdata_i[ELEMENT_WIDTH-1:0]),
    .last_i       (s_axis_tlast_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

[dv/vector_l2_normalizer_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for vector_l2_normalizer: push and pop beats on the stream ports.
// A scoreboard class works out each reply from its own copy of the vector state.
// Depends on vl2n_pkg and the vector_l2_normalizer top level.

import vl2n_pkg::*;

localparam int unsigned TB_VEC_LEN = 512;

typedef struct packed {
  logic [OUT_W-1:0] value;
  logic             final_elem;
  logic             status;
} l2_reply_t;

class norm_scoreboard;
  logic signed [15:0] elem_store [TB_VEC_LEN];
  logic [SUM_W-1:0]   sq_sum;
  logic [NORM_W-1:0]  norm;
  int unsigned        elem_count;
  int unsigned        rd_pos;
  bit                 vec_ready;
  l2_reply_t          expected_replies[$];
  int unsigned        errors, pushes, pops, empties, vectors;

  function new();
    clear_vector();
    errors = 0; pushes = 0; pops = 0; empties = 0; vectors = 0;
  endfunction

  function void clear_vector();
    sq_sum = '0;
    norm = '0;
    elem_count = 0;
    rd_pos = 0;
    vec_ready = 0;
  endfunction

  function int unsigned pending();
    return expected_replies.size();
  endfunction

  function logic [16:0] magnitude(logic signed [15:0] v);
    return v[15] ? 17'(~{v[15], v} + 17'd1) : {1'b0, v};
  endfunction

  // digit-by-digit root, two sum bits per step
  function logic [NORM_W-1:0] int_sqrt(logic [SUM_W-1:0] x);
    logic [23:0]       rem;
    logic [23:0]       trial;
    logic [NORM_W-1:0] root;
    rem  = '0;
    root = '0;
    for (int i = NORM_W - 1; i >= 0; i--) begin
      rem   = (rem << 2) | 24'(x[2*i+1 -: 2]);
      trial = (24'(root) << 2) | 24'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem     = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  function void note_beat(logic mode, logic [15:0] data, logic lst);
    logic signed [15:0] elem;
    logic [16:0]        mag;
    logic [SUM_W:0]     total;
    logic [31:0]        quot;
    l2_reply_t          rep;
    if (mode == MODE_PUSH) begin
      pushes++;
      elem = data;
      if (vec_ready) clear_vector();
      // a full buffer drops the element but still honours its last flag
      if (elem_count < TB_VEC_LEN) begin
        mag = magnitude(elem);
        elem_store[elem_count] = elem;
        elem_count++;
        total = {1'b0, sq_sum} + (41'(mag) * 41'(mag));
        sq_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
      end
      if (lst) begin
        norm = int_sqrt(sq_sum);
        rd_pos = 0;
        vec_ready = 1;
        vectors++;
      end
      return;
    end
    pops++;
    rep = '0;
    if (!vec_ready || rd_pos >= elem_count) begin
      rep.status = STATUS_EMPTY;
      empties++;
    end else begin
      elem = elem_store[rd_pos];
      rep.status = STATUS_OK;
      rep.final_elem = (rd_pos + 1 == elem_count);
      // zero norm leaves the value at zero
      if (norm != '0) begin
        mag  = magnitude(elem);
        quot = {mag, 15'd0} / 32'(norm);
        if (elem < 0) begin
          if (quot > 32'd32768) quot = 32'd32768;
          rep.value = 16'(32'd0 - quot);
        end else begin
          if (quot > 32'd32767) quot = 32'd32767;
          rep.value = quot[15:0];
        end
      end
      if (rep.final_elem) clear_vector();
      else rd_pos++;
    end
    expected_replies.push_back(rep);
  endfunction

  function void check_reply(logic [15:0] value, logic lst, logic status);
    l2_reply_t exp_rep;
    if (expected_replies.size() == 0) begin
      $error("unexpected reply beat: normalized_value %0d", $signed(value));
      errors++;
      return;
    end
    exp_rep = expected_replies.pop_front();
    if (value !== exp_rep.value) begin
      $error("normalized_value: expected %0d, got %0d", $signed(exp_rep.value), $signed(value));
      errors++;
    end
    if (lst !== exp_rep.final_elem) begin
      $error("last_element: expected %0b, got %0b", exp_rep.final_elem, lst);
      errors++;
    end
    if (status !== exp_rep.status) begin
      $error("status: expected %0b, got %0b", exp_rep.status, status);
      errors++;
    end
  endfunction
endclass

module vector_l2_normalizer_tb;
  import vl2n_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             s_tvalid;
  logic             s_tready;
  logic [15:0]      s_tdata;
  logic             s_tuser;
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             m_tlast;

  norm_scoreboard sb = new();
  int unsigned    beats_in = 0;
  int unsigned    beats_out = 0;
  bit             rx_hold_req = 1'b0;

  vector_l2_normalizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // element_value
    .s_axis_tuser_i  (s_tuser),   // mode
    .s_axis_tlast_i  (s_tlast),   // last
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // normalized_value
    .m_axis_tuser_o  (m_tuser),   // status
    .m_axis_tlast_o  (m_tlast)    // last_element
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // reply side: random stalls, a calm stretch, and one long hold-off on request
  initial begin : reply_side
    int unsigned hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) begin
        sb.check_reply(m_tdata, m_tlast, m_tuser);
        beats_out++;
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (beats_out >= 500 && beats_out < 760) || ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic send_beat(input logic mode, input logic [15:0] value, input logic lst);
    while (!(beats_in >= 500 && beats_in < 760) && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= mode;
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_tready);
    sb.note_beat(mode, value, lst);
    beats_in++;
  endtask

  // style: 0 full range, 1 extremes, 2 small, 3 zeros
  function automatic logic [15:0] pick_value(int unsigned style);
    case (style)
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0001;
          3: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      2: return 16'($urandom_range(127)) - 16'd64;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic push_vector(input int unsigned len, input int unsigned style);
    for (int unsigned k = 0; k < len; k++)
      send_beat(MODE_PUSH, pick_value(style), k == len - 1);
  endtask

  // data and last are ignored on a pop, so they carry noise
  task automatic pop_n(input int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      send_beat(MODE_POP, 16'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    send_beat(MODE_POP, 16'h0000, 1'b0);     // nothing loaded since reset
    send_beat(MODE_PUSH, 16'h7FFF, 1'b0);
    send_beat(MODE_PUSH, 16'h8000, 1'b0);
    send_beat(MODE_POP, 16'hFFFF, 1'b1);     // vector still loading
    send_beat(MODE_PUSH, 16'h0000, 1'b0);
    send_beat(MODE_PUSH, 16'h0001, 1'b0);
    send_beat(MODE_PUSH, 16'hFFFF, 1'b1);
    pop_n(6);                                // last one finds no vector
    send_beat(MODE_PUSH, 16'h7FFF, 1'b1);    // exact +1 saturates
    pop_n(1);
    send_beat(MODE_PUSH, 16'h8000, 1'b1);    // exact -1
    pop_n(1);
    send_beat(MODE_PUSH, 16'h0000, 1'b0);    // zero norm
    send_beat(MODE_PUSH, 16'h0000, 1'b1);
    pop_n(2);
    push_vector(3, 0);
    pop_n(1);
    push_vector(2, 0);                       // throws away the unread remainder
    pop_n(3);
  endtask

  task automatic run_random();
    int unsigned sel, len, style;
    while (beats_in < 1350) begin
      sel   = $urandom_range(99);
      len   = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      style = $urandom_range(99);
      style = (style < 70) ? 0 : (style < 80) ? 1 : (style < 90) ? 2 : 3;
      if (sel < 65) begin
        push_vector(len, style);
        pop_n(len + ($urandom_range(4) == 0));
      end else if (sel < 75) begin
        for (int unsigned k = 0; k < len; k++) begin
          send_beat(MODE_PUSH, pick_value(style), k == len - 1);
          if (k != len - 1 && $urandom_range(3) == 0) pop_n(1);
        end
        pop_n(len);
      end else if (sel < 85) begin
        push_vector(len, style);
        pop_n($urandom_range(len - 1));
      end else begin
        repeat ($urandom_range(6, 1))
          send_beat(1'($urandom), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= MODE_PUSH;
    s_tlast  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();

    // reply side holds off while pops keep coming, then the sender waits it out
    push_vector(16, 0);
    rx_hold_req = 1'b1;
    pop_n(16);
    drain();

    // overfill the buffer; a few reads, then the next vector discards the rest
    push_vector(TB_VEC_LEN + 3, 0);
    pop_n(6);

    run_random();
    drain();
    repeat (50) @(posedge clk_i);

    $display("run covered %0d push beats and %0d pop beats over %0d closed vectors",
             sb.pushes, sb.pops, sb.vectors);
    $display("%0d pops found no finished vector", sb.empties);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/vl2n_pkg.sv
rtl/vl2n_sqrt.sv
rtl/vl2n_div.sv
rtl/vl2n_dp.sv
rtl/vl2n_ctrl.sv
rtl/vector_l2_normalizer.sv
dv/vector_l2_normalizer_tb.sv
